/* rtl/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// shared widths, opcodes, defaults and a helper function of the page allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

	localparam int ADDR_W = 32;
	localparam int OP_W   = 2;

	// opcodes of an input transaction
	localparam logic [OP_W-1:0] OP_FREE  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// default geometry
	localparam int DEF_MAP_WORDS     = 1024;
	localparam int DEF_BITS_PER_WORD = 32;
	localparam int DEF_PAGE_SHIFT    = 12;

	// widest map word the lowest-bit search supports
	localparam int MAX_WORD_BITS = 64;
	localparam int MAX_IDX_W     = 6;

	// index of the lowest set bit, zero when none is set
	function automatic logic [MAX_IDX_W-1:0] find_first(input logic [MAX_WORD_BITS-1:0] w);
		logic [MAX_IDX_W-1:0] idx;
		idx = '0;
		for (int i = MAX_WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = MAX_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

/* rtl/bpa_if.sv */
// ----------------------------------------------------------------------------
// bpa_if
// valid/ready channels for request and result transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_in_if;
	import bpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [ADDR_W-1:0] page_addr_in;

	modport source (output valid, output opcode, output page_addr_in, input ready);
	modport sink   (input valid, input opcode, input page_addr_in, output ready);
endinterface

interface bpa_out_if;
	import bpa_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] page_addr_out;
	logic              found;

	modport source (output valid, output page_addr_out, output found, input ready);
	modport sink   (input valid, input page_addr_out, input found, output ready);
endinterface

`default_nettype wire

/* rtl/bpa_ram.sv */
// ----------------------------------------------------------------------------
// bpa_ram
// generic single-clock ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/bpa_pgdiv.sv */
// ----------------------------------------------------------------------------
// bpa_pgdiv
// split of a page number into map word and bit by reciprocal multiplication
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_pgdiv #(
	parameter int DIVIDEND_W = 20,
	parameter int DIVISOR    = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [DIVIDEND_W-1:0]         dividend,
	output logic                               done,
	output logic      [DIVIDEND_W-1:0]         quot,
	output logic      [$clog2(DIVISOR)-1:0]    rem
);

	localparam int RW  = $clog2(DIVISOR);
	localparam int SH  = DIVIDEND_W + RW;
	localparam int MW  = DIVIDEND_W + 1;
	localparam int PRW = DIVIDEND_W + MW;

	// ceil(2^SH / DIVISOR), exact quotient for every dividend of DIVIDEND_W bits
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	logic                  pend_q;
	logic                  done_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVIDEND_W-1:0] quot_q;
	logic [PRW-1:0]        prod;

	// dividend registered first, quotient registered in the cycle after
	assign prod = PRW'(num_q) * PRW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pend_q <= start;
			done_q <= pend_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
		end
		if (pend_q) begin
			quot_q <= DIVIDEND_W'(prod[PRW-1:SH]);
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	// remainder is below the divisor, so the low bits are enough
	assign rem  = num_q[RW-1:0] - RW'(quot_q * DIVIDEND_W'(DIVISOR));

endmodule

`default_nettype wire

/* rtl/bitmap_page_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// physical page allocator over a free bitmap held in a synchronous ram
// ----------------------------------------------------------------------------
// The map holds one bit per page (1 = free) in MAP_WORDS words of
// BITS_PER_WORD bits. After reset, and after a clear, a sweep writes every map
// word to zero, one word per cycle, and no transaction is taken until all
// MAP_WORDS words (1024 at the default size) are written. In a free
// transaction the page number is split into word and bit by a reciprocal
// multiplication that registers the dividend, then the quotient; then the
// word is read, the bit set and written back. An allocate transaction scans
// the map one word per cycle, starting at a low-water mark below which every
// word is known to be zero, and skips the scan when the map is known to be
// empty. Its result is held back while the previous result still waits in
// the output register. The scan reads one word per cycle through the single
// ram read port. Only allocate returns a result transaction; a finished
// result waits in an output register while the next request is taken.
// Opcode 3 and frees beyond the map are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator_unit #(
	parameter int MAP_WORDS     = bpa_pkg::DEF_MAP_WORDS,
	parameter int BITS_PER_WORD = bpa_pkg::DEF_BITS_PER_WORD,
	parameter int PAGE_SHIFT    = bpa_pkg::DEF_PAGE_SHIFT
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bpa_in_if.sink    in_ch,
	bpa_out_if.source out_ch
);

	import bpa_pkg::*;

	// page number, word index, low-water mark, bit index and compare widths
	localparam int PW  = ADDR_W - PAGE_SHIFT;
	localparam int WW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int HW  = $clog2(MAP_WORDS + 1);
	localparam int BIW = $clog2(BITS_PER_WORD);
	localparam int CW  = (PW > HW) ? PW : HW;

	localparam logic [BITS_PER_WORD-1:0] ONE_W = BITS_PER_WORD'(1);

	// sequencer states
	localparam logic [2:0] S_INIT    = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_DIV     = 3'd2;
	localparam logic [2:0] S_FREE_WR = 3'd3;
	localparam logic [2:0] S_SCAN    = 3'd4;
	localparam logic [2:0] S_RES     = 3'd5;

	logic [2:0]  state_q;
	logic [WW-1:0] clr_q;      // clearing sweep pointer
	logic [WW-1:0] scan_q;     // word whose data the ram returns this cycle
	logic [HW-1:0] hint_q;     // every word below this one is zero
	logic        out_valid_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic        res_found_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic        out_found_q;

	// ram port
	logic                     mem_we;
	logic [WW-1:0]            mem_waddr;
	logic [BITS_PER_WORD-1:0] mem_wdata;
	logic                     mem_re;
	logic [WW-1:0]            mem_raddr;
	logic [BITS_PER_WORD-1:0] mem_rdata;

	// page split
	logic          div_start;
	logic          div_done;
	logic [PW-1:0] div_quot;
	logic [BIW-1:0] div_rem;

	logic           in_acc;
	logic           map_empty;
	logic           in_range;
	logic [WW-1:0]  word_s;
	logic [BIW-1:0] first_s;
	logic [BITS_PER_WORD-1:0] take_mask;
	logic [BITS_PER_WORD-1:0] remain_s;
	logic [ADDR_W-1:0] page_s;
	logic [ADDR_W-1:0] alloc_addr;
	logic           last_word;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign map_empty   = (hint_q == HW'(MAP_WORDS));

	bpa_ram #(
		.WIDTH (BITS_PER_WORD),
		.DEPTH (MAP_WORDS),
		.AW    (WW)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign div_start = in_acc && (in_ch.opcode == OP_FREE);

	bpa_pgdiv #(
		.DIVIDEND_W (PW),
		.DIVISOR    (BITS_PER_WORD)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_ch.page_addr_in[ADDR_W-1:PAGE_SHIFT]),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// freed page must land inside the map
	assign in_range = CW'(div_quot) < CW'(MAP_WORDS);
	assign word_s   = WW'(div_quot);

	// lowest free page in the word being scanned
	assign first_s    = BIW'(find_first(MAX_WORD_BITS'(mem_rdata)));
	assign take_mask  = ONE_W << first_s;
	assign remain_s   = mem_rdata & ~take_mask;
	assign page_s     = ADDR_W'(scan_q) * ADDR_W'(BITS_PER_WORD) + ADDR_W'(first_s);
	assign alloc_addr = page_s << PAGE_SHIFT;
	assign last_word  = (scan_q == WW'(MAP_WORDS - 1));

	// ram access per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = scan_q;
		case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				if (in_acc && (in_ch.opcode == OP_ALLOC) && !map_empty) begin
					mem_re    = 1'b1;
					mem_raddr = WW'(hint_q);
				end
			end
			S_DIV: begin
				if (div_done && in_range) begin
					mem_re    = 1'b1;
					mem_raddr = word_s;
				end
			end
			S_FREE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = word_s;
				mem_wdata = mem_rdata | (ONE_W << div_rem);
			end
			S_SCAN: begin
				if (mem_rdata != '0) begin
					mem_we    = 1'b1;
					mem_waddr = scan_q;
					mem_wdata = remain_s;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = scan_q + WW'(1);
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			scan_q      <= '0;
			hint_q      <= HW'(MAP_WORDS);
			out_valid_q <= 1'b0;
		end else begin
			// output register loads a new result or drains when taken
			if ((state_q == S_RES) && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					clr_q <= clr_q + WW'(1);
					if (clr_q == WW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						case (in_ch.opcode)
							OP_FREE: begin
								state_q <= S_DIV;
							end
							OP_ALLOC: begin
								scan_q  <= WW'(hint_q);
								state_q <= map_empty ? S_RES : S_SCAN;
							end
							OP_CLEAR: begin
								clr_q   <= '0;
								hint_q  <= HW'(MAP_WORDS);
								state_q <= S_INIT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= in_range ? S_FREE_WR : S_IDLE;
					end
				end
				S_FREE_WR: begin
					if (HW'(word_s) < hint_q) begin
						hint_q <= HW'(word_s);
					end
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (mem_rdata != '0) begin
						// word left empty moves the mark past it
						hint_q  <= (remain_s == '0) ? HW'(scan_q) + HW'(1) : HW'(scan_q);
						state_q <= S_RES;
					end else if (last_word) begin
						hint_q  <= HW'(MAP_WORDS);
						state_q <= S_RES;
					end else begin
						scan_q <= scan_q + WW'(1);
					end
				end
				S_RES: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_addr_q  <= '0;
				res_found_q <= 1'b0;
			end
			S_SCAN: begin
				if (mem_rdata != '0) begin
					res_addr_q  <= alloc_addr;
					res_found_q <= 1'b1;
				end
			end
			S_RES: begin
				if (!out_valid_q || out_ch.ready) begin
					out_addr_q  <= res_addr_q;
					out_found_q <= res_found_q;
				end
			end
			default: begin
				res_found_q <= res_found_q;
			end
		endcase
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.page_addr_out = out_addr_q;
	assign out_ch.found         = out_found_q;

`ifndef SYNTHESIS
	// no map write while waiting for a transaction
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("map written while idle");

	// divider finishes only while the sequencer waits on it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its state");

	// a freed page is written back only inside the map
	a_free_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FREE_WR |-> CW'(div_quot) < CW'(MAP_WORDS))
		else $error("free write outside the map");

	// scan never looks below the low-water mark
	a_scan_above_mark: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> HW'(scan_q) >= hint_q)
		else $error("scan below low-water mark");

	// a failed allocate leaves the map marked empty
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && !out_found_q |-> hint_q == HW'(MAP_WORDS))
		else $error("allocate failed with free pages marked");
`endif

endmodule

`default_nettype wire

/* dv/tb_bitmap_page_allocator_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_unit
// self-checking bench for the bitmap page allocator
// ----------------------------------------------------------------------------
// Requests go in over the request channel and every allocate result is checked
// against a predictor that keeps its own copy of the free bitmap. Directed
// tests cover the corner cases, then random traffic mixes frees, allocates,
// clears and dropped requests, with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_bitmap_page_allocator_unit;
	import bpa_pkg::*;

	localparam int MAP_WORDS     = DEF_MAP_WORDS;
	localparam int BITS_PER_WORD = DEF_BITS_PER_WORD;
	localparam int PAGE_SHIFT    = DEF_PAGE_SHIFT;
	localparam int MAP_PAGES     = MAP_WORDS * BITS_PER_WORD;

	// no opcode in the package for the spare encoding
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// settle wait: long enough for a clear sweep or a full-map scan, plus margin
	localparam int SETTLE_CYCLES = MAP_WORDS + 64;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              found;
	} page_grant_t;

	logic clk = 1'b0;
	logic arst_n;

	bpa_in_if  in_ch ();
	bpa_out_if out_ch ();

	bitmap_page_allocator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor state: one bit per page, set = free
	logic [BITS_PER_WORD-1:0] free_words [MAP_WORDS];
	page_grant_t              grants_due [$];
	int                       failures = 0;
	bit                       calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic void release_page(input logic [ADDR_W-1:0] addr);
		int unsigned page;
		int unsigned word;
		page = addr >> PAGE_SHIFT;
		word = page / BITS_PER_WORD;
		// pages past the last map word are dropped
		if (word < MAP_WORDS) begin
			free_words[word][page % BITS_PER_WORD] = 1'b1;
		end
	endfunction

	function automatic page_grant_t take_lowest_page();
		page_grant_t g;
		g.addr  = '0;
		g.found = 1'b0;
		for (int w = 0; w < MAP_WORDS; w++) begin
			if (free_words[w] != '0) begin
				for (int b = 0; b < BITS_PER_WORD; b++) begin
					if (free_words[w][b]) begin
						free_words[w][b] = 1'b0;
						g.addr  = ADDR_W'((w * BITS_PER_WORD + b) << PAGE_SHIFT);
						g.found = 1'b1;
						return g;
					end
				end
			end
		end
		// nothing free: address zero with found low
		return g;
	endfunction

	function automatic void clear_map();
		foreach (free_words[i]) begin
			free_words[i] = '0;
		end
	endfunction

	// byte address somewhere inside the given page, low bits random
	function automatic logic [ADDR_W-1:0] addr_of_page(input int unsigned page);
		logic [ADDR_W-1:0] low_bits;
		low_bits = ADDR_W'($urandom) & ((ADDR_W'(1) << PAGE_SHIFT) - 1);
		return (ADDR_W'(page) << PAGE_SHIFT) | low_bits;
	endfunction

	// ------------------------------------------------------------------------
	// request driver: one transaction, then maybe a short idle burst
	// ------------------------------------------------------------------------

	task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
		in_ch.valid        <= 1'b1;
		in_ch.opcode       <= op;
		in_ch.page_addr_in <= addr;
		do @(posedge clk); while (!in_ch.ready);
		// transaction accepted at this edge, update the predictor in order
		case (op)
			OP_FREE:  release_page(addr);
			OP_ALLOC: grants_due.push_back(take_lowest_page());
			OP_CLEAR: clear_map();
			default:  ;
		endcase
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// hold off new requests until every outstanding grant has been checked
	task automatic wait_for_grants();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (grants_due.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// result side: random backpressure and the checker
	// ------------------------------------------------------------------------

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_grants
		page_grant_t due;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (grants_due.size() == 0) begin
				$error("unexpected result transaction: page_addr_out %h found %b",
					out_ch.page_addr_out, out_ch.found);
				failures++;
			end else begin
				due = grants_due.pop_front();
				if (out_ch.found !== due.found) begin
					$error("found mismatch: expected %b, got %b", due.found, out_ch.found);
					failures++;
				end
				if (out_ch.page_addr_out !== due.addr) begin
					$error("page_addr_out mismatch: expected %h, got %h",
						due.addr, out_ch.page_addr_out);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------------

	// map is all allocated right after reset
	task automatic test_alloc_when_empty();
		send_request(OP_ALLOC, '0);
	endtask

	// page zero comes back as address zero, found tells it from failure
	task automatic test_page_zero();
		send_request(OP_FREE, 32'h0000_0FFF);
		send_request(OP_ALLOC, 32'hFFFF_FFFF);
	endtask

	// freeing a free page twice leaves one page to take
	task automatic test_repeat_free();
		send_request(OP_FREE, addr_of_page(7));
		send_request(OP_FREE, addr_of_page(7));
		send_request(OP_ALLOC, '0);
		send_request(OP_ALLOC, '0);
	endtask

	// last page of the map and both sides of a word boundary, lowest first
	task automatic test_map_edges();
		send_request(OP_FREE, addr_of_page(MAP_PAGES - 1));
		send_request(OP_FREE, addr_of_page(BITS_PER_WORD - 1));
		send_request(OP_FREE, addr_of_page(BITS_PER_WORD));
		repeat (3) send_request(OP_ALLOC, '0);
	endtask

	// addresses past the map are dropped
	task automatic test_beyond_map();
		send_request(OP_FREE, ADDR_W'(MAP_PAGES) << PAGE_SHIFT);
		send_request(OP_FREE, 32'hFFFF_FFFF);
		send_request(OP_ALLOC, '0);
	endtask

	// spare opcode does nothing to the map
	task automatic test_unused_opcode();
		send_request(OP_FREE, addr_of_page(9));
		send_request(OP_UNUSED, 32'hFFFF_FFFF);
		send_request(OP_ALLOC, '0);
	endtask

	// clear drops every free page
	task automatic test_clear();
		send_request(OP_FREE, addr_of_page(2));
		send_request(OP_FREE, addr_of_page(100));
		send_request(OP_CLEAR, $urandom);
		send_request(OP_ALLOC, '0);
	endtask

	// ------------------------------------------------------------------------
	// random tests
	// ------------------------------------------------------------------------

	// mostly low pages so grants are common, some anywhere, some raw 32-bit
	function automatic logic [ADDR_W-1:0] pick_free_addr();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			return addr_of_page($urandom_range(0, 511));
		end else if (pick < 9) begin
			return addr_of_page($urandom_range(0, MAP_PAGES - 1));
		end
		return $urandom;
	endfunction

	// mixed traffic; dropped requests come on top of the count
	task automatic test_random_mix(input int count);
		int unsigned pick;
		int          sent;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_request(OP_FREE, pick_free_addr());
				sent++;
			end else if (pick < 91) begin
				send_request(OP_ALLOC, $urandom);
				sent++;
			end else if (pick < 95) begin
				send_request(OP_UNUSED, $urandom);
			end else if (pick < 99) begin
				send_request(OP_FREE, $urandom_range(32'hFFFF_FFFF,
					ADDR_W'(MAP_PAGES) << PAGE_SHIFT));
			end else begin
				send_request(OP_CLEAR, $urandom);
				sent++;
			end
		end
	endtask

	// free a handful of pages in one region, then allocate that many plus up to three more
	task automatic test_fill_and_drain(input int episodes);
		int unsigned base;
		int unsigned burst;
		for (int e = 0; e < episodes; e++) begin
			base  = $urandom_range(0, MAP_WORDS - 2) * BITS_PER_WORD;
			burst = $urandom_range(1, 24);
			repeat (burst) send_request(OP_FREE, addr_of_page(base + $urandom_range(0, 63)));
			repeat (burst + $urandom_range(0, 3)) send_request(OP_ALLOC, $urandom);
			if (e == episodes / 2) begin
				wait_for_grants();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n             <= 1'b0;
		in_ch.valid        <= 1'b0;
		in_ch.opcode       <= OP_FREE;
		in_ch.page_addr_in <= '0;
		clear_map();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alloc_when_empty();
		test_page_zero();
		test_repeat_free();
		test_map_edges();
		test_beyond_map();
		test_unused_opcode();
		test_clear();

		test_random_mix(1000);
		test_fill_and_drain(12);
		wait_for_grants();

		// last stretch runs without idling on either side
		calm = 1'b1;
		test_random_mix(250);

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (grants_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#80ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
